>>> rtl/leib_pkg.sv
// Shared constants for the line-edit input buffer: character codes, result
// kinds, register indexes and reset values. No dependencies.
package leib_pkg;

  localparam int DEFAULT_RING_DEPTH = 64;

  localparam logic [6:0] MAX_READ = 7'd64;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NONE  = 8'h00;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] REG_BACKSPACE = 2'd0;
  localparam logic [1:0] REG_ENTER     = 2'd1;
  localparam logic [1:0] REG_TAB       = 2'd2;

  localparam logic [7:0] RST_BACKSPACE = 8'd8;
  localparam logic [7:0] RST_ENTER     = 8'd13;
  localparam logic [7:0] RST_TAB       = 8'd9;

endpackage

>>> rtl/leib_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module leib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/line_edit_input_buffer_core.sv
// Line-edit input buffer: top level. Keeps positions and key registers in flops
// and the character ring in one leib_ram instance. Depends on leib_pkg, leib_ram.
//
// Items are taken while busy is low. A key item is handled in the accept cycle:
// its echo (if any) appears on the result ports the next cycle, and a backspace
// keeps busy high through ST_BS_SPACE and ST_BS_LAST while it sends space and
// backspace. A read item that finds committed bytes keeps busy high in ST_READ
// while it returns up to 64 bytes: the first byte is fetched in the accept cycle
// and each later one while the previous one is sent. An empty read, or a key
// with no effect, leaves busy low. Every result is shown for exactly one cycle
// with strobe high, in the cycle after it is formed.
module line_edit_input_buffer_core #(
  parameter int RING_DEPTH = leib_pkg::DEFAULT_RING_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [7:0] key_code,
  input  logic [6:0] max_bytes,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       strobe,
  output logic [1:0] kind,
  output logic [7:0] char_out,
  output logic       line_ready,
  output logic       last
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = $clog2(2 * RING_DEPTH);
  localparam logic [PW:0]   TWO_D   = (PW+1)'(2 * RING_DEPTH);
  localparam logic [PW-1:0] POS_MAX = PW'(2 * RING_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_READ     = 2'd1;
  localparam logic [1:0] ST_BS_SPACE = 2'd2;
  localparam logic [1:0] ST_BS_LAST  = 2'd3;

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    pos_inc = (p == POS_MAX) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
    pos_dec = (p == '0) ? POS_MAX : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] pos_dist(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] wrapped;
    wrapped  = {1'b0, a} + TWO_D - {1'b0, b};
    pos_dist = (a >= b) ? (a - b) : wrapped[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] pos_idx(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r       = (p >= DEPTH_P) ? (p - DEPTH_P) : p;
    pos_idx = r[AW-1:0];
  endfunction

  // Registers
  logic [1:0]    state, state_next;
  logic [PW-1:0] read_pos, read_pos_next;
  logic [PW-1:0] commit_pos, commit_pos_next;
  logic [PW-1:0] edit_pos, edit_pos_next;
  logic [6:0]    left, left_next;
  logic [7:0]    backspace_code, enter_code, tab_code;
  logic          strobe_next, line_ready_next, last_next;
  logic [1:0]    kind_next;
  logic [7:0]    char_next;

  // Ring RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q;

  logic          accept;
  logic [7:0]    key_ch;
  logic [PW-1:0] edit_inc;
  logic [PW-1:0] read_inc;
  logic          key_commit;
  logic [6:0]    limit;

  assign accept   = start && (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign edit_inc = pos_inc(edit_pos);
  assign read_inc = pos_inc(read_pos);
  assign limit    = (max_bytes > leib_pkg::MAX_READ) ? leib_pkg::MAX_READ : max_bytes;

  always_comb begin
    if (key_code == enter_code) begin
      key_ch = leib_pkg::CH_NL;
    end else if (key_code == tab_code) begin
      key_ch = leib_pkg::CH_TAB;
    end else begin
      key_ch = key_code;
    end
  end

  assign key_commit = (key_ch == leib_pkg::CH_NL) ||
                      (pos_dist(edit_inc, read_pos) == DEPTH_P);

  always_comb begin
    state_next      = state;
    read_pos_next   = read_pos;
    commit_pos_next = commit_pos;
    edit_pos_next   = edit_pos;
    left_next       = left;
    strobe_next     = 1'b0;
    kind_next       = leib_pkg::KIND_ECHO;
    char_next       = leib_pkg::CH_NONE;
    line_ready_next = 1'b0;
    last_next       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = pos_idx(edit_pos);
    ram_wdata       = key_ch;

    unique case (state)
      ST_IDLE: begin
        if (accept && !mode) begin
          if (key_code == leib_pkg::CH_NONE) begin
            // no key: nothing to do
          end else if (key_code == backspace_code) begin
            if (edit_pos != commit_pos) begin
              edit_pos_next = pos_dec(edit_pos);
              strobe_next   = 1'b1;
              char_next     = leib_pkg::CH_BS;
              state_next    = ST_BS_SPACE;
            end
          end else if (pos_dist(edit_pos, read_pos) < DEPTH_P) begin
            ram_we          = 1'b1;
            edit_pos_next   = edit_inc;
            if (key_commit) begin
              commit_pos_next = edit_inc;
            end
            strobe_next     = 1'b1;
            char_next       = key_ch;
            line_ready_next = key_commit;
            last_next       = 1'b1;
          end
        end else if (accept && mode && (limit != 7'd0)) begin
          if (read_pos == commit_pos) begin
            strobe_next = 1'b1;
            kind_next   = leib_pkg::KIND_EMPTY;
            last_next   = 1'b1;
          end else begin
            // RAM is addressed with read_pos this cycle; byte arrives next cycle
            left_next  = limit;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        strobe_next   = 1'b1;
        kind_next     = leib_pkg::KIND_BYTE;
        char_next     = ram_q;
        read_pos_next = read_inc;
        left_next     = left - 7'd1;
        if ((ram_q == leib_pkg::CH_NL) || (left == 7'd1) || (read_inc == commit_pos)) begin
          last_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_BS_SPACE: begin
        strobe_next = 1'b1;
        char_next   = leib_pkg::CH_SPACE;
        state_next  = ST_BS_LAST;
      end
      ST_BS_LAST: begin
        strobe_next = 1'b1;
        char_next   = leib_pkg::CH_BS;
        last_next   = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Writes come only from key items and read data is used only by read items;
  // items are handled one at a time, so a write never meets a read that is used.
  leib_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pos_idx(read_pos_next)),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      read_pos       <= '0;
      commit_pos     <= '0;
      edit_pos       <= '0;
      left           <= '0;
      strobe         <= 1'b0;
      backspace_code <= leib_pkg::RST_BACKSPACE;
      enter_code     <= leib_pkg::RST_ENTER;
      tab_code       <= leib_pkg::RST_TAB;
    end else begin
      state      <= state_next;
      read_pos   <= read_pos_next;
      commit_pos <= commit_pos_next;
      edit_pos   <= edit_pos_next;
      left       <= left_next;
      strobe     <= strobe_next;
      if (cfg_we) begin
        unique case (cfg_index)
          leib_pkg::REG_BACKSPACE: backspace_code <= cfg_data;
          leib_pkg::REG_ENTER:     enter_code     <= cfg_data;
          leib_pkg::REG_TAB:       tab_code       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind       <= kind_next;
    char_out   <= char_next;
    line_ready <= line_ready_next;
    last       <= last_next;
  end

  // A read stream only runs while committed bytes remain.
  a_read_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (read_pos != commit_pos))
    else $error("read in progress with nothing committed");

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    pos_dist(edit_pos, read_pos) <= DEPTH_P)
    else $error("ring holds more than its depth");

  a_commit_order: assert property (@(posedge clk) disable iff (rst)
    pos_dist(commit_pos, read_pos) <= pos_dist(edit_pos, read_pos))
    else $error("commit position beyond edit position");

  a_bs_sequence: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BS_LAST) |-> ($past(state) == ST_BS_SPACE))
    else $error("backspace echo out of sequence");

  a_ready_on_echo: assert property (@(posedge clk) disable iff (rst)
    (strobe && line_ready) |-> ((kind == leib_pkg::KIND_ECHO) && last))
    else $error("line_ready on a word other than a final echo");

endmodule
